>>> rtl/swrt_pkg.sv
`default_nettype none
package swrt_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned LEN_W     = 11;
  localparam logic [LEN_W-1:0] LEN_MAX = 11'd2047;

  localparam logic MODE_REQUEST = 1'b0;
  localparam logic MODE_ARRIVAL = 1'b1;

  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_DELIVER = 1'b1;

  typedef enum logic [11:0] {
    ST_IDLE      = 12'b0000_0000_0001,
    ST_CHECK     = 12'b0000_0000_0010,
    ST_ARR_REL   = 12'b0000_0000_0100,
    ST_ARR_IDX   = 12'b0000_0000_1000,
    ST_ARR_MARK  = 12'b0000_0001_0000,
    ST_REQ_SCAN  = 12'b0000_0010_0000,
    ST_TAIL_DIV  = 12'b0000_0100_0000,
    ST_TAIL_OUT  = 12'b0000_1000_0000,
    ST_DRAIN_RD  = 12'b0001_0000_0000,
    ST_DRAIN_OUT = 12'b0010_0000_0000,
    ST_DRAIN_CMP = 12'b0100_0000_0000,
    ST_FLUSH     = 12'b1000_0000_0000
  } state_t;

  typedef struct packed {
    logic              kind;
    logic [DATA_W-1:0] offset;
    logic [LEN_W-1:0]  length;
    logic              complete;
  } result_t;

  function automatic logic [LEN_W-1:0] sat_len(input logic [16:0] v);
    logic [LEN_W-1:0] r;
    r = (v > 17'(LEN_MAX)) ? LEN_MAX : v[LEN_W-1:0];
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/swrt_ram.sv
`default_nettype none
module swrt_ram #(
  parameter int unsigned WIDTH = 11,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/sliding_window_receive_tracker.sv
`default_nettype none
// Selective-repeat receive window tracker. An item is taken only while the
// sequencer is idle, and it then works alone around a single shared 32-bit
// add/subtract unit. A request round scans at most WINDOW_SLOTS window slots;
// a tail request finds total_bytes modulo SEGMENT_BYTES by a reciprocal
// multiply and one correcting subtract. An arrival locates its slot by
// stepping through the slot indices, then delivers in-order segments one at
// a time, each through the registered read of the slot length memory and
// the add-then-compare through the shared unit.
// One result is held back internally so the final one can carry last. The
// slot length memory needs no clearing pass.
module sliding_window_receive_tracker
  import swrt_pkg::*;
#(
  parameter int unsigned WINDOW_SLOTS  = 32,
  parameter int unsigned SEGMENT_BYTES = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [DATA_W-1:0] cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              mode,
  input  wire logic [DATA_W-1:0] segment_offset,
  input  wire logic [LEN_W-1:0]  segment_length,
  input  wire logic              sender_matches,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   kind,
  output logic      [DATA_W-1:0] offset,
  output logic      [LEN_W-1:0]  length,
  output logic                   last,
  output logic                   complete
);

  localparam int unsigned IDX_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam int unsigned CNT_W = (IDX_W > 5) ? IDX_W : 5;
  localparam int unsigned SEG_W = $clog2(SEGMENT_BYTES + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_SLOTS - 1);
  localparam logic [CNT_W-1:0] SLOT_CNT_LAST = CNT_W'(WINDOW_SLOTS - 1);
  localparam logic [CNT_W-1:0] TAIL_QUOT = CNT_W'(0);
  localparam logic [CNT_W-1:0] TAIL_PROD = CNT_W'(1);
  localparam logic [CNT_W-1:0] TAIL_DIFF = CNT_W'(2);
  localparam logic [DATA_W-1:0] SEG_WORD = DATA_W'(SEGMENT_BYTES);
  localparam logic [DATA_W:0] SEG_RECIP =
    (DATA_W + 1)'((64'd1 << DATA_W) / 64'(SEGMENT_BYTES));
  localparam logic [16:0] SEG_17 = 17'(SEGMENT_BYTES);
  localparam logic [LEN_W-1:0] SEG_LEN_SAT = sat_len(SEG_17);

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
    logic [IDX_W-1:0] r;
    r = (p == IDX_LAST) ? '0 : p + 1'b1;
    return r;
  endfunction

  state_t state;

  logic [DATA_W-1:0] total_bytes;
  logic [DATA_W-1:0] delivered_bytes;
  logic [IDX_W-1:0]  head_slot;
  logic [WINDOW_SLOTS-1:0] slot_filled;

  // captured request
  logic              req_mode;
  logic [DATA_W-1:0] req_offset;
  logic [LEN_W-1:0]  req_length;
  logic              req_sender;

  // sequencer working registers
  logic [DATA_W-1:0] acc;
  logic [DATA_W-1:0] off_acc;
  logic [IDX_W-1:0]  ptr;
  logic [CNT_W-1:0]  cnt;
  logic [SEG_W-1:0]  rem;
  logic [LEN_W-1:0]  drain_len;

  // held-back result
  logic    pend_valid;
  result_t pend;

  // shared add/subtract unit
  logic [DATA_W-1:0] alu_a;
  logic [DATA_W-1:0] alu_b;
  logic              alu_sub;
  logic [DATA_W:0]   alu_res;
  logic              alu_carry;
  logic              alu_zero;
  logic              alu_borrow;
  logic              alu_le;

  logic [DATA_W-1:0] tail_quo;
  logic              out_free;
  logic              put_ok;
  logic              put_fire;
  logic              flush_fire;
  result_t           put_data;

  logic [LEN_W-1:0]  ram_rdata;
  logic              ram_we;
  logic              ram_re;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign out_free  = !out_valid || out_ready;
  assign put_ok    = !pend_valid || out_free;
  // quotient estimate, low by at most one
  assign tail_quo  = DATA_W'((64'(total_bytes) * 64'(SEG_RECIP)) >> DATA_W);

  always_comb begin
    alu_a   = total_bytes;
    alu_b   = delivered_bytes;
    alu_sub = 1'b1;
    case (state)
      ST_ARR_REL: begin
        alu_a = req_offset;
      end
      ST_ARR_IDX, ST_REQ_SCAN: begin
        alu_a = acc;
        alu_b = SEG_WORD;
      end
      ST_TAIL_DIV: begin
        if (cnt == TAIL_DIFF) begin
          alu_b = off_acc;
        end else begin
          alu_a = acc;
          alu_b = SEG_WORD;
        end
      end
      ST_TAIL_OUT: begin
        alu_b = DATA_W'(rem);
      end
      ST_DRAIN_OUT: begin
        alu_a   = delivered_bytes;
        alu_b   = DATA_W'(ram_rdata);
        alu_sub = 1'b0;
      end
      default: begin
      end
    endcase
    alu_res = {1'b0, alu_a} + {1'b0, (alu_b ^ {DATA_W{alu_sub}})} + (DATA_W + 1)'(alu_sub);
  end

  assign alu_carry  = alu_res[DATA_W];
  assign alu_zero   = (alu_res[DATA_W-1:0] == '0);
  assign alu_borrow = !alu_carry;
  // a <= b on a subtraction
  assign alu_le     = alu_borrow || alu_zero;

  always_comb begin
    put_fire = 1'b0;
    put_data = '{kind: KIND_REQUEST, offset: off_acc, length: SEG_LEN_SAT, complete: 1'b0};
    case (state)
      ST_REQ_SCAN: begin
        put_fire = alu_carry && !slot_filled[ptr] && put_ok;
      end
      ST_TAIL_OUT: begin
        put_fire = put_ok;
        put_data = '{kind: KIND_REQUEST, offset: alu_res[DATA_W-1:0],
                     length: sat_len(17'(rem)), complete: 1'b0};
      end
      ST_DRAIN_CMP: begin
        put_fire = put_ok;
        put_data = '{kind: KIND_DELIVER, offset: off_acc, length: drain_len,
                     complete: alu_le};
      end
      default: begin
      end
    endcase
  end

  assign flush_fire = (state == ST_FLUSH) && pend_valid && out_free;
  assign ram_we = (state == ST_ARR_MARK) && !slot_filled[ptr];
  assign ram_re = (state == ST_DRAIN_RD);

  swrt_ram #(
    .WIDTH (LEN_W),
    .DEPTH (WINDOW_SLOTS)
  ) u_len_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ptr),
    .wdata (req_length),
    .re    (ram_re),
    .raddr (head_slot),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      total_bytes     <= '0;
      delivered_bytes <= '0;
      head_slot       <= '0;
      slot_filled     <= '0;
      pend_valid      <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        total_bytes <= cfg_data;
      end

      // output register and held-back result
      if (put_fire) begin
        if (pend_valid) begin
          out_valid <= 1'b1;
          kind      <= pend.kind;
          offset    <= pend.offset;
          length    <= pend.length;
          complete  <= pend.complete;
          last      <= 1'b0;
        end else if (out_ready) begin
          out_valid <= 1'b0;
        end
        pend       <= put_data;
        pend_valid <= 1'b1;
      end else if (flush_fire) begin
        out_valid  <= 1'b1;
        kind       <= pend.kind;
        offset     <= pend.offset;
        length     <= pend.length;
        complete   <= pend.complete;
        last       <= 1'b1;
        pend_valid <= 1'b0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            req_mode   <= mode;
            req_offset <= segment_offset;
            req_sender <= sender_matches;
            // stored length saturates at the segment size
            req_length <= ({6'b0, segment_length} > SEG_17) ? SEG_17[LEN_W-1:0]
                                                           : segment_length;
            state      <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          acc     <= alu_res[DATA_W-1:0];
          ptr     <= head_slot;
          cnt     <= '0;
          off_acc <= delivered_bytes;
          if (alu_le) begin
            state <= ST_IDLE;
          end else if (req_mode == MODE_REQUEST) begin
            state <= ST_REQ_SCAN;
          end else if (!req_sender) begin
            state <= ST_IDLE;
          end else begin
            state <= ST_ARR_REL;
          end
        end
        ST_ARR_REL: begin
          acc <= alu_res[DATA_W-1:0];
          // drop a segment behind the window
          state <= alu_borrow ? ST_IDLE : ST_ARR_IDX;
        end
        ST_ARR_IDX: begin
          if (alu_borrow) begin
            state <= ST_ARR_MARK;
          end else if (cnt == SLOT_CNT_LAST) begin
            // beyond the window
            state <= ST_IDLE;
          end else begin
            acc <= alu_res[DATA_W-1:0];
            ptr <= wrap_inc(ptr);
            cnt <= cnt + 1'b1;
          end
        end
        ST_ARR_MARK: begin
          if (slot_filled[ptr]) begin
            state <= ST_IDLE;
          end else begin
            slot_filled[ptr] <= 1'b1;
            state            <= ST_DRAIN_RD;
          end
        end
        ST_DRAIN_RD: begin
          state <= slot_filled[head_slot] ? ST_DRAIN_OUT : ST_FLUSH;
        end
        ST_DRAIN_OUT: begin
          off_acc   <= delivered_bytes;
          drain_len <= ram_rdata;
          delivered_bytes <= alu_carry ? '1 : alu_res[DATA_W-1:0];
          slot_filled[head_slot] <= 1'b0;
          head_slot <= wrap_inc(head_slot);
          state     <= ST_DRAIN_CMP;
        end
        ST_DRAIN_CMP: begin
          if (put_ok) begin
            state <= ST_DRAIN_RD;
          end
        end
        ST_REQ_SCAN: begin
          if (alu_borrow) begin
            // no full segment left at all: fall back to the tail request
            if (cnt == '0) begin
              off_acc <= total_bytes;
              rem     <= '0;
              state   <= ST_TAIL_DIV;
            end else begin
              state <= ST_FLUSH;
            end
          end else if (slot_filled[ptr] || put_ok) begin
            acc     <= alu_res[DATA_W-1:0];
            off_acc <= off_acc + SEG_WORD;
            ptr     <= wrap_inc(ptr);
            cnt     <= cnt + 1'b1;
            if (cnt == SLOT_CNT_LAST) begin
              state <= ST_FLUSH;
            end
          end
        end
        ST_TAIL_DIV: begin
          // remainder estimate lies below twice the segment size; one subtract fixes it
          case (cnt)
            TAIL_QUOT: begin
              acc <= tail_quo;
            end
            TAIL_PROD: begin
              off_acc <= acc * SEG_WORD;
            end
            TAIL_DIFF: begin
              acc <= alu_res[DATA_W-1:0];
            end
            default: begin
              rem   <= alu_borrow ? acc[SEG_W-1:0] : alu_res[SEG_W-1:0];
              state <= ST_TAIL_OUT;
            end
          endcase
          cnt <= cnt + 1'b1;
        end
        ST_TAIL_OUT: begin
          if (put_ok) begin
            state <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (!pend_valid || out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
